FILE: src/fde_pkg.sv
// Package for the feedback delay echo: widths, register indexes, reset values.
// No dependencies; used by the interfaces, the mixer and the top level.
`default_nettype none

package fde_pkg;

    localparam int FRAMES_W   = 16;
    localparam int CHANS_W    = 4;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = FRAMES_W + CHANS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MIX_SHIFT  = 15;

    localparam logic [GAIN_W-1:0]   GAIN_ONE       = 16'h8000;
    localparam logic [FRAMES_W-1:0] FRAMES_RST     = 16'd8192;
    localparam logic [CHANS_W-1:0]  CHANS_RST      = 4'd2;
    localparam logic [GAIN_W-1:0]   FB_GAIN_RST    = 16'd16384;
    localparam logic [GAIN_W-1:0]   WET_GAIN_RST   = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_FRAMES  = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_FEEDBACK_GAIN = 2'd2,
        REG_WET_GAIN      = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: src/fde_if.sv
// Valid/ready channel interfaces for the feedback delay echo: sample input,
// result output and configuration writes. Depends on fde_pkg.
`default_nettype none

interface fde_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fde_result_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface fde_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fde_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [fde_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

FILE: src/fde_mix.sv
// Q1.15 crossfade of a dry and a delayed sample: round half up, shift by 15,
// saturate to the sample range. Depends on fde_pkg.
`default_nettype none

module fde_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] dry,
    input  logic signed [SAMPLE_BITS-1:0] delayed,
    input  logic [fde_pkg::GAIN_W-1:0]    gain,
    output logic signed [SAMPLE_BITS-1:0] mixed
);
    import fde_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_W + 2;
    localparam int RW = PW - MIX_SHIFT;
    localparam logic signed [RW-1:0] MAXV = {{(RW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [RW-1:0] MINV = ~MAXV;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) <<< (MIX_SHIFT - 1);

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [GAIN_W:0]      gain_s;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        sum;
    logic signed [RW-1:0]        res;

    // a*(1-g) + d*g == a + (d-a)*g
    always_comb
    begin
        diff   = {delayed[SAMPLE_BITS-1], delayed} - {dry[SAMPLE_BITS-1], dry};
        gain_s = $signed({1'b0, gain});
        prod   = diff * gain_s;
        sum    = (PW'(dry) <<< MIX_SHIFT) + prod + ROUND_HALF;
        res    = sum[PW-1:MIX_SHIFT];
        if (res > MAXV)
        begin
            mixed = MAXV[SAMPLE_BITS-1:0];
        end
        else if (res < MINV)
        begin
            mixed = MINV[SAMPLE_BITS-1:0];
        end
        else
        begin
            mixed = res[SAMPLE_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/feedback_delay_echo.sv
// Feedback delay echo: a sample passes the stage and output registers; throughput is
// one sample per cycle unless results stall, set by one store read and write per cycle.
// Reset: registers to defaults, store reads as zero for its first pass via a
// first-lap flag (no clearing pass); a length change restarts that pass.
// Depends on fde_pkg, fde_if and fde_mix.
`default_nettype none

module feedback_delay_echo #(
    parameter int MAX_DEPTH   = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    fde_sample_if.sink         samples,
    fde_result_if.source       results,
    fde_cfg_if.sink            cfg
);
    import fde_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_DEPTH);
    localparam int LEN_W   = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W   = (LEN_W > PROD_W) ? LEN_W : PROD_W;
    localparam int RST_PRD = 8192 * 2;
    localparam int RST_LEN = (RST_PRD > MAX_DEPTH) ? MAX_DEPTH : RST_PRD;

    logic [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [CHANS_W-1:0]  chans_reg, chans_next;
    logic [GAIN_W-1:0]   fb_gain_reg, fb_gain_next;
    logic [GAIN_W-1:0]   wet_gain_reg, wet_gain_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic                first_lap_reg, first_lap_next;
    logic                s1_valid_reg, s1_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [ADDR_W-1:0]             s1_addr_reg;
    logic                          s1_zero_reg;
    logic                          s1_fwd_reg;
    logic signed [SAMPLE_BITS-1:0] fwd_data_reg;
    logic signed [SAMPLE_BITS-1:0] mem_q_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic                          cfg_wr;
    logic                          len_write;
    logic [PROD_W-1:0]             prod;
    logic [CMP_W-1:0]              prod_ext;
    logic [LEN_W-1:0]              len_calc;
    logic [GAIN_W-1:0]             gain_clamped;
    logic [LEN_W-1:0]              ptr_inc;
    logic                          wrap;
    logic                          s1_adv;
    logic                          in_acc;
    logic                          hazard;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [SAMPLE_BITS-1:0] wet_mix;
    logic signed [SAMPLE_BITS-1:0] fb_mix;

    assign cfg.ready       = 1'b1;
    assign cfg_wr          = cfg.valid;
    assign s1_adv          = !out_valid_reg || results.ready;
    assign samples.ready   = !s1_valid_reg || s1_adv;
    assign in_acc          = samples.valid && samples.ready;
    assign hazard          = s1_valid_reg && (s1_addr_reg == ptr_reg);
    assign results.valid      = out_valid_reg;
    assign results.sample_out = out_sample_reg;

    assign delayed = s1_fwd_reg ? fwd_data_reg :
                     (s1_zero_reg ? '0 : mem_q_reg);

    fde_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_wet_mix (
        .dry     (s1_sample_reg),
        .delayed (delayed),
        .gain    (wet_gain_reg),
        .mixed   (wet_mix)
    );

    fde_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_fb_mix (
        .dry     (s1_sample_reg),
        .delayed (delayed),
        .gain    (fb_gain_reg),
        .mixed   (fb_mix)
    );

    // configuration
    always_comb
    begin
        frames_next   = frames_reg;
        chans_next    = chans_reg;
        fb_gain_next  = fb_gain_reg;
        wet_gain_next = wet_gain_reg;
        len_write     = 1'b0;
        gain_clamped  = (cfg.wdata > GAIN_ONE) ? GAIN_ONE : cfg.wdata;
        if (cfg_wr)
        begin
            case (cfg.reg_index)
                REG_DELAY_FRAMES:
                begin
                    frames_next = cfg.wdata;
                    len_write   = 1'b1;
                end
                REG_CHANNEL_COUNT:
                begin
                    chans_next = cfg.wdata[CHANS_W-1:0];
                    len_write  = 1'b1;
                end
                REG_FEEDBACK_GAIN: fb_gain_next  = gain_clamped;
                REG_WET_GAIN:      wet_gain_next = gain_clamped;
                default: ;
            endcase
        end
        prod     = frames_next * chans_next;
        prod_ext = CMP_W'(prod);
        if (prod == '0)
        begin
            len_calc = LEN_W'(1);
        end
        else if (prod_ext > CMP_W'(MAX_DEPTH))
        begin
            len_calc = LEN_W'(MAX_DEPTH);
        end
        else
        begin
            len_calc = prod_ext[LEN_W-1:0];
        end
    end

    // pointer and pipeline control
    always_comb
    begin
        ptr_inc        = LEN_W'(ptr_reg) + LEN_W'(1);
        wrap           = ptr_inc >= len_reg;
        ptr_next       = ptr_reg;
        first_lap_next = first_lap_reg;
        len_next       = len_reg;
        if (in_acc)
        begin
            if (wrap)
            begin
                ptr_next       = '0;
                first_lap_next = 1'b0;
            end
            else
            begin
                ptr_next = ptr_inc[ADDR_W-1:0];
            end
        end
        if (len_write && (len_calc != len_reg))
        begin
            len_next       = len_calc;
            ptr_next       = '0;
            first_lap_next = 1'b1;
        end

        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= FRAMES_RST;
            chans_reg     <= CHANS_RST;
            fb_gain_reg   <= FB_GAIN_RST;
            wet_gain_reg  <= WET_GAIN_RST;
            len_reg       <= LEN_W'(RST_LEN);
            ptr_reg       <= '0;
            first_lap_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frames_reg    <= frames_next;
            chans_reg     <= chans_next;
            fb_gain_reg   <= fb_gain_next;
            wet_gain_reg  <= wet_gain_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            first_lap_reg <= first_lap_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage payload; forward the slot being written when it is read next
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= samples.sample_in;
            s1_addr_reg   <= ptr_reg;
            s1_zero_reg   <= first_lap_reg;
            s1_fwd_reg    <= hazard;
            fwd_data_reg  <= fb_mix;
        end
        if (s1_valid_reg && s1_adv)
        begin
            out_sample_reg <= wet_mix;
        end
    end

    // delay store: read at the pointer, write back the feedback mix
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mem_q_reg <= mem[ptr_reg];
        end
        if (s1_valid_reg && s1_adv)
        begin
            mem[s1_addr_reg] <= fb_mix;
        end
    end

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(ptr_reg) < len_reg)
        else $error("write pointer beyond active length");

    a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv) |=> out_valid_reg)
        else $error("stage transaction lost before output register");

    a_lap_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_lap_reg) |-> (ptr_reg == '0))
        else $error("first pass ended without pointer wrap");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> samples.ready)
        else $error("input stalled with empty stage");
`endif

endmodule

`default_nettype wire
